[src/sliding_window_min_max_sum_macros.svh]
// ---------------------------------------------------------------------------
// Sliding window min/max/sum - assertion macros
// Shared concurrent check wrappers on clk_i, masked while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MIN_MAX_SUM_MACROS_SVH
`define SLIDING_WINDOW_MIN_MAX_SUM_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define SWMM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication out of reset
`define SWMM_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[src/swmm_pkg.sv]
// ---------------------------------------------------------------------------
// Sliding window min/max/sum - package
// Fixed widths, reset values and state encodings shared by the block.
// ---------------------------------------------------------------------------
package swmm_pkg;

  // Configuration register
  localparam int unsigned CFG_W = 7;
  localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 7'd4;

  // Running total, saturating
  localparam int unsigned TOTAL_W = 48;
  localparam logic signed [TOTAL_W-1:0] TOTAL_HI = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic signed [TOTAL_W-1:0] TOTAL_LO = {1'b1, {(TOTAL_W-1){1'b0}}};

  // Request queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Deque sequencer
  typedef enum logic [1:0] {
    DQ_IDLE,
    DQ_EVAL,
    DQ_HEAD_WAIT,
    DQ_TAIL_WAIT
  } dq_state_e;

  // Back-end controller
  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bk_state_e;

endpackage

[src/swmm_if.sv]
// ---------------------------------------------------------------------------
// Sliding window min/max/sum - channel interfaces
// Valid/ready channels for configuration, samples and results.
// ---------------------------------------------------------------------------

// Configuration write channel
interface swmm_cfg_if import swmm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] window_size;

  modport source (output valid, window_size, input ready);
  modport sink   (input valid, window_size, output ready);
endinterface

// Sample channel
interface swmm_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last_sample;

  modport source (output valid, sample, last_sample, input ready);
  modport sink   (input valid, sample, last_sample, output ready);
endinterface

// Result channel
interface swmm_out_if import swmm_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic                          window_full;
  logic signed [SAMPLE_BITS-1:0] window_max;
  logic signed [SAMPLE_BITS-1:0] window_min;
  logic signed [TOTAL_W-1:0]     running_total;
  logic                          stream_done;

  modport source (output valid, window_full, window_max, window_min, running_total,
                  stream_done, input ready);
  modport sink   (input valid, window_full, window_max, window_min, running_total,
                  stream_done, output ready);
endinterface

[src/swmm_ram.sv]
// ---------------------------------------------------------------------------
// Sliding window min/max/sum - generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module swmm_ram #(
  parameter  int unsigned WIDTH  = 8,
  parameter  int unsigned DEPTH  = 64,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/swmm_front.sv]
// ---------------------------------------------------------------------------
// Sliding window min/max/sum - front end
// Holds the window size, tags each sample with position, effective
// window and window-full flag, and pushes the request into the queue.
// ---------------------------------------------------------------------------
module swmm_front import swmm_pkg::*; #(
  parameter  int unsigned WINDOW_MAX  = 64,
  parameter  int unsigned SAMPLE_BITS = 16,
  localparam int unsigned CNT_W       = $clog2(WINDOW_MAX + 1),
  localparam int unsigned ENT_W       = SAMPLE_BITS + 2 + 2 * CNT_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  swmm_cfg_if.sink         cfg_i,
  swmm_in_if.sink          smp_i,
  output logic             q_valid_o,
  output logic [ENT_W-1:0] q_data_o,
  input  logic             q_ready_i
);

  logic [CFG_W-1:0] window_size_q, window_size_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] fill_next;
  logic             full;
  logic             accept;

  // Config channel never stalls
  assign cfg_i.ready = 1'b1;

  // Effective window: zero means one, clamp to the deque depth
  always_comb begin
    if (window_size_q == '0) begin
      k = CNT_W'(1);
    end else if (32'(window_size_q) > WINDOW_MAX) begin
      k = CNT_W'(WINDOW_MAX);
    end else begin
      k = CNT_W'(window_size_q);
    end
  end

  // Fill count saturates at the deque depth
  assign fill_next = (fill_q == CNT_W'(WINDOW_MAX)) ? fill_q : fill_q + CNT_W'(1);
  assign full      = (fill_next >= k);

  // Request to the back end
  assign accept      = smp_i.valid && q_ready_i;
  assign smp_i.ready = q_ready_i;
  assign q_valid_o   = smp_i.valid;
  assign q_data_o    = {smp_i.sample, smp_i.last_sample, full, pos_q, k};

  // Stream counters, cleared after the last sample
  always_comb begin
    window_size_d = window_size_q;
    pos_d         = pos_q;
    fill_d        = fill_q;
    if (cfg_i.valid) begin
      window_size_d = cfg_i.window_size;
    end
    if (accept) begin
      if (smp_i.last_sample) begin
        pos_d  = '0;
        fill_d = '0;
      end else begin
        pos_d  = pos_q + CNT_W'(1);
        fill_d = fill_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WINDOW_SIZE_RESET;
      pos_q         <= '0;
      fill_q        <= '0;
    end else begin
      window_size_q <= window_size_d;
      pos_q         <= pos_d;
      fill_q        <= fill_d;
    end
  end

endmodule

[src/swmm_queue.sv]
// ---------------------------------------------------------------------------
// Sliding window min/max/sum - request queue
// Small register FIFO that decouples the front end from the back end.
// ---------------------------------------------------------------------------
module swmm_queue #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 2,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output logic [WIDTH-1:0] pop_data_o,
  input  logic             pop_ready_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[src/swmm_deque.sv]
// ---------------------------------------------------------------------------
// Sliding window min/max/sum - monotonic deque
// Keeps the running maximum of the window: drops stale entries at the
// head, dominated entries at the tail, then pushes. Feed inverted
// samples to obtain the minimum.
// ---------------------------------------------------------------------------
`include "sliding_window_min_max_sum_macros.svh"

module swmm_deque import swmm_pkg::*; #(
  parameter  int unsigned WINDOW_MAX  = 64,
  parameter  int unsigned SAMPLE_BITS = 16,
  localparam int unsigned CNT_W       = $clog2(WINDOW_MAX + 1),
  localparam int unsigned IDX_W       = $clog2(WINDOW_MAX)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [CNT_W-1:0]              pos_i,
  input  logic [CNT_W-1:0]              k_i,
  input  logic                          last_i,
  output logic                          done_o,
  output logic                          idle_o,
  output logic signed [SAMPLE_BITS-1:0] head_o
);

  localparam int unsigned ENT_W = SAMPLE_BITS + CNT_W;

  dq_state_e                     state_q, state_d;
  logic [IDX_W-1:0]              head_q, head_d;
  logic [CNT_W-1:0]              count_q, count_d;
  logic signed [SAMPLE_BITS-1:0] hd_val_q, hd_val_d;
  logic [CNT_W-1:0]              hd_pos_q, hd_pos_d;
  logic signed [SAMPLE_BITS-1:0] tl_val_q, tl_val_d;
  logic signed [SAMPLE_BITS-1:0] v_q, v_d;
  logic [CNT_W-1:0]              pos_q, pos_d;
  logic [CNT_W-1:0]              k_q, k_d;
  logic                          last_q, last_d;

  logic [CNT_W-1:0]              age;
  logic                          stale, dominated, many;
  logic [IDX_W-1:0]              idx_next, idx_prev, idx_push;
  logic                          ram_we, ram_re;
  logic [IDX_W-1:0]              ram_raddr;
  logic [ENT_W-1:0]              ram_rdata;
  logic signed [SAMPLE_BITS-1:0] rd_val;
  logic [CNT_W-1:0]              rd_pos;

  // Circular index: sums stay below twice the depth
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [CNT_W:0] s);
    logic [CNT_W:0] r;
    r = (s >= (CNT_W+1)'(WINDOW_MAX)) ? s - (CNT_W+1)'(WINDOW_MAX) : s;
    return r[IDX_W-1:0];
  endfunction

  // Head / tail conditions from the cached end entries
  assign age       = pos_q - hd_pos_q;
  assign stale     = (count_q != '0) && (age >= k_q);
  assign dominated = (count_q != '0) && (tl_val_q <= v_q);
  assign many      = (count_q > CNT_W'(1));

  assign idx_next = wrap_idx((CNT_W+1)'(head_q) + (CNT_W+1)'(1));
  assign idx_prev = wrap_idx((CNT_W+1)'(head_q) + (CNT_W+1)'(count_q) - (CNT_W+1)'(2));
  assign idx_push = wrap_idx((CNT_W+1)'(head_q) + (CNT_W+1)'(count_q));

  assign rd_val = ram_rdata[ENT_W-1 -: SAMPLE_BITS];
  assign rd_pos = ram_rdata[CNT_W-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DQ_IDLE: begin
        if (start_i) begin
          state_d = DQ_EVAL;
        end
      end
      DQ_EVAL: begin
        priority if (stale) begin
          state_d = many ? DQ_HEAD_WAIT : DQ_EVAL;
        end else if (dominated) begin
          state_d = many ? DQ_TAIL_WAIT : DQ_EVAL;
        end else begin
          state_d = DQ_IDLE;
        end
      end
      DQ_HEAD_WAIT: state_d = DQ_EVAL;
      DQ_TAIL_WAIT: state_d = DQ_EVAL;
    endcase
  end

  // Outputs and RAM control
  always_comb begin
    done_o    = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = idx_next;
    unique case (state_q)
      DQ_EVAL: begin
        priority if (stale) begin
          ram_re    = many;
          ram_raddr = idx_next;
        end else if (dominated) begin
          ram_re    = many;
          ram_raddr = idx_prev;
        end else begin
          done_o = 1'b1;
          ram_we = (count_q != CNT_W'(WINDOW_MAX));
        end
      end
      DQ_IDLE, DQ_HEAD_WAIT, DQ_TAIL_WAIT: begin
      end
    endcase
  end

  assign idle_o = (state_q == DQ_IDLE);
  assign head_o = (count_q == '0) ? v_q : hd_val_q;

  // Deque pointers and cached end entries
  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    hd_val_d = hd_val_q;
    hd_pos_d = hd_pos_q;
    tl_val_d = tl_val_q;
    v_d      = v_q;
    pos_d    = pos_q;
    k_d      = k_q;
    last_d   = last_q;
    unique case (state_q)
      DQ_IDLE: begin
        if (start_i) begin
          v_d    = sample_i;
          pos_d  = pos_i;
          k_d    = k_i;
          last_d = last_i;
        end
      end
      DQ_EVAL: begin
        priority if (stale) begin
          head_d  = idx_next;
          count_d = count_q - CNT_W'(1);
        end else if (dominated) begin
          count_d = count_q - CNT_W'(1);
        end else begin
          tl_val_d = v_q;
          if (count_q == '0) begin
            hd_val_d = v_q;
            hd_pos_d = pos_q;
          end
          if (last_q) begin
            head_d  = '0;
            count_d = '0;
          end else if (count_q != CNT_W'(WINDOW_MAX)) begin
            count_d = count_q + CNT_W'(1);
          end
        end
      end
      DQ_HEAD_WAIT: begin
        hd_val_d = rd_val;
        hd_pos_d = rd_pos;
      end
      DQ_TAIL_WAIT: begin
        tl_val_d = rd_val;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DQ_IDLE;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hd_val_q <= hd_val_d;
    hd_pos_q <= hd_pos_d;
    tl_val_q <= tl_val_d;
    v_q      <= v_d;
    pos_q    <= pos_d;
    k_q      <= k_d;
    last_q   <= last_d;
  end

  // Entry store: value and position
  swmm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (WINDOW_MAX)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_push),
    .wdata_i ({v_q, pos_q}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Checks
  `SWMM_ASSERT_IMPL(a_start_when_idle, start_i, state_q == DQ_IDLE, "deque started while busy")
  `SWMM_ASSERT(a_count_bound, count_q <= CNT_W'(WINDOW_MAX), "deque count beyond depth")

endmodule

[src/swmm_back.sv]
// ---------------------------------------------------------------------------
// Sliding window min/max/sum - back end
// Runs both deques on each queued request, accumulates the saturating
// total and holds the result in an output register.
// ---------------------------------------------------------------------------
`include "sliding_window_min_max_sum_macros.svh"

module swmm_back import swmm_pkg::*; #(
  parameter  int unsigned WINDOW_MAX  = 64,
  parameter  int unsigned SAMPLE_BITS = 16,
  localparam int unsigned CNT_W       = $clog2(WINDOW_MAX + 1),
  localparam int unsigned ENT_W       = SAMPLE_BITS + 2 + 2 * CNT_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  logic [ENT_W-1:0] q_data_i,
  output logic             q_ready_o,
  swmm_out_if.source       res_o
);

  bk_state_e state_q, state_d;

  // Request fields
  logic signed [SAMPLE_BITS-1:0] ent_sample;
  logic                          ent_last, ent_full;
  logic [CNT_W-1:0]              ent_pos, ent_k;

  // Deque handshakes
  logic                          start;
  logic                          max_done, min_done, max_idle, min_idle;
  logic signed [SAMPLE_BITS-1:0] max_head, min_head_inv;
  logic                          max_done_q, max_done_d, min_done_q, min_done_d;
  logic signed [SAMPLE_BITS-1:0] mx_q, mx_d, mn_q, mn_d;
  logic                          full_q, full_d, last_q, last_d;

  // Accumulate
  logic                          emit;
  logic signed [SAMPLE_BITS-1:0] mx, mn;
  logic signed [SAMPLE_BITS:0]   pair;
  logic signed [TOTAL_W:0]       sum_ext;
  logic signed [TOTAL_W-1:0]     sat;
  logic signed [TOTAL_W-1:0]     total_q, total_d;

  // Output register
  logic                          res_valid_q, res_valid_d;
  logic                          res_full_q, res_done_q;
  logic signed [SAMPLE_BITS-1:0] res_max_q, res_min_q;
  logic signed [TOTAL_W-1:0]     res_total_q;

  assign ent_sample = q_data_i[ENT_W-1 -: SAMPLE_BITS];
  assign ent_last   = q_data_i[2*CNT_W+1];
  assign ent_full   = q_data_i[2*CNT_W];
  assign ent_pos    = q_data_i[2*CNT_W-1 -: CNT_W];
  assign ent_k      = q_data_i[CNT_W-1:0];

  // Deque results, live or held
  assign mx   = max_done ? max_head : mx_q;
  assign mn   = min_done ? ~min_head_inv : mn_q;
  assign pair = (SAMPLE_BITS+1)'(mx) + (SAMPLE_BITS+1)'(mn);

  // Saturating running total
  assign sum_ext = (TOTAL_W+1)'(total_q) + (TOTAL_W+1)'(pair);
  always_comb begin
    if (sum_ext[TOTAL_W] != sum_ext[TOTAL_W-1]) begin
      sat = sum_ext[TOTAL_W] ? TOTAL_LO : TOTAL_HI;
    end else begin
      sat = sum_ext[TOTAL_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (start) begin
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (emit) begin
          state_d = BK_IDLE;
        end
      end
    endcase
  end

  // Controller outputs
  always_comb begin
    start = 1'b0;
    emit  = 1'b0;
    unique case (state_q)
      BK_IDLE: start = q_valid_i && (!res_valid_q || res_o.ready);
      BK_RUN:  emit  = (max_done_q || max_done) && (min_done_q || min_done);
    endcase
  end

  assign q_ready_o = start;

  // Per-request bookkeeping, total and output register
  always_comb begin
    max_done_d  = max_done_q || max_done;
    min_done_d  = min_done_q || min_done;
    mx_d        = mx;
    mn_d        = mn;
    full_d      = full_q;
    last_d      = last_q;
    total_d     = total_q;
    res_valid_d = res_valid_q && !res_o.ready;
    if (start) begin
      full_d = ent_full;
      last_d = ent_last;
    end
    if (emit) begin
      max_done_d  = 1'b0;
      min_done_d  = 1'b0;
      res_valid_d = 1'b1;
      if (last_q) begin
        total_d = '0;
      end else if (full_q) begin
        total_d = sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      max_done_q  <= 1'b0;
      min_done_q  <= 1'b0;
      total_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      max_done_q  <= max_done_d;
      min_done_q  <= min_done_d;
      total_q     <= total_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q   <= mx_d;
    mn_q   <= mn_d;
    full_q <= full_d;
    last_q <= last_d;
    if (emit) begin
      res_full_q  <= full_q;
      res_max_q   <= full_q ? mx : '0;
      res_min_q   <= full_q ? mn : '0;
      res_total_q <= full_q ? sat : total_q;
      res_done_q  <= last_q;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.window_full   = res_full_q;
  assign res_o.window_max    = res_max_q;
  assign res_o.window_min    = res_min_q;
  assign res_o.running_total = res_total_q;
  assign res_o.stream_done   = res_done_q;

  // Maximum deque
  swmm_deque #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_max (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .sample_i (ent_sample),
    .pos_i    (ent_pos),
    .k_i      (ent_k),
    .last_i   (ent_last),
    .done_o   (max_done),
    .idle_o   (max_idle),
    .head_o   (max_head)
  );

  // Minimum deque: maximum over inverted samples
  swmm_deque #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_min (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .sample_i (~ent_sample),
    .pos_i    (ent_pos),
    .k_i      (ent_k),
    .last_i   (ent_last),
    .done_o   (min_done),
    .idle_o   (min_idle),
    .head_o   (min_head_inv)
  );

  // Checks
  `SWMM_ASSERT_IMPL(a_start_deques_idle, start, max_idle && min_idle, "deques busy on new request")
  `SWMM_ASSERT_IMPL(a_emit_reg_free, emit, !res_valid_q || res_o.ready, "result register overrun")

endmodule

[src/sliding_window_min_max_sum.sv]
// ---------------------------------------------------------------------------
// Sliding window min/max/sum - top level
// Streaming window maximum and minimum with a saturating running total.
// ---------------------------------------------------------------------------
// Each accepted sample gives exactly one result. Once window_size samples of
// the current stream have arrived, the result carries the window maximum and
// minimum, and max + min is added to a 48-bit total that clamps at its range
// limits; before that the max and min read zero and the total is unchanged.
// A sample with last_sample set ends the stream: its result shows the final
// total with stream_done high, then the stream state clears (the window size
// register is kept). A window size of zero acts as one, one above WINDOW_MAX
// acts as WINDOW_MAX; write it only while the block is idle. The front end
// takes a sample per cycle into a two-entry request queue while the queue has
// room. The back end runs two deque sequencers in parallel, each on one RAM
// with registered read. In each deque, every entry dropped at its head or
// tail adds a step, and each drop that leaves the deque non-empty adds a RAM
// read to refresh the cached end entry; the slower deque sets the time. Every
// sample is dropped at most once from each deque. The back end takes a new
// request only when it is idle, so a long run of drops holds off the queue.
// A result waiting in the output register holds off the next request.
// There is no clearing pass after reset.
// ---------------------------------------------------------------------------
module sliding_window_min_max_sum import swmm_pkg::*; #(
  parameter int unsigned WINDOW_MAX  = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  swmm_cfg_if.sink   cfg_i,
  swmm_in_if.sink    smp_i,
  swmm_out_if.source res_o
);

  localparam int unsigned CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int unsigned ENT_W = SAMPLE_BITS + 2 + 2 * CNT_W;

  logic             fq_valid, fq_ready;
  logic [ENT_W-1:0] fq_data;
  logic             qb_valid, qb_ready;
  logic [ENT_W-1:0] qb_data;

  // Front end: config and request tagging
  swmm_front #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .smp_i     (smp_i),
    .q_valid_o (fq_valid),
    .q_data_o  (fq_data),
    .q_ready_i (fq_ready)
  );

  // Request queue
  swmm_queue #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_data_i  (fq_data),
    .push_ready_o (fq_ready),
    .pop_valid_o  (qb_valid),
    .pop_data_o   (qb_data),
    .pop_ready_i  (qb_ready)
  );

  // Back end: deques, total and result register
  swmm_back #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (qb_valid),
    .q_data_i  (qb_data),
    .q_ready_o (qb_ready),
    .res_o     (res_o)
  );

endmodule
